// File: src/luhn_card_number_checker_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Luhn card number checker
// Clocked immediate-implication and next-cycle-implication checks.
// ----------------------------------------------------------------------------
`ifndef LUHN_CARD_NUMBER_CHECKER_MACROS_SVH
`define LUHN_CARD_NUMBER_CHECKER_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define LCC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante
`define LCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/lcc_pkg.sv
// ----------------------------------------------------------------------------
// Luhn card number checker package
// Word types, issuer codes, length constants and digit arithmetic helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package lcc_pkg;

    // Default saturation point of the digit counter
    localparam int MAX_DIGITS_DEF = 31;

    // Width of the reported digit count
    localparam int COUNT_OUT_W = 5;

    // Number lengths used by the issuer rules
    localparam int LEN_THIRTEEN = 13;
    localparam int LEN_FIFTEEN  = 15;
    localparam int LEN_SIXTEEN  = 16;

    // Issuer class codes
    typedef enum logic [1:0] {
        ISS_NONE       = 2'd0,
        ISS_FIFTEEN_3X = 2'd1,
        ISS_SIXTEEN_5X = 2'd2,
        ISS_LEAD_FOUR  = 2'd3
    } t_issuer;

    // Input word: one digit plus end-of-number mark
    typedef struct packed {
        logic [3:0] digit;
        logic       last;
    } t_digit_word;

    // Result word
    typedef struct packed {
        logic                   valid_res;
        t_issuer                issuer;
        logic [COUNT_OUT_W-1:0] digit_count;
    } t_result_word;

    // Luhn contribution of a doubled digit, codes above nine included
    localparam logic [3:0] DBL_TAB [16] = '{
        4'd0, 4'd2, 4'd4, 4'd6, 4'd8, 4'd1, 4'd3, 4'd5,
        4'd7, 4'd9, 4'd1, 4'd3, 4'd5, 4'd7, 4'd9, 4'd1
    };

    // Plain contribution: digit modulo ten
    function automatic logic [3:0] plain_val(input logic [3:0] d);
        logic [3:0] r;
        if (d inside {[4'd10:4'd15]}) begin
            r = d - 4'd10;
        end else begin
            r = d;
        end
        return r;
    endfunction

    // Sum of two values below ten, modulo ten
    function automatic logic [3:0] add_mod10(input logic [3:0] a, input logic [3:0] b);
        logic [4:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= 5'd10) begin
            s = s - 5'd10;
        end
        return s[3:0];
    endfunction

endpackage

`default_nettype wire

// File: src/lcc_stream_if.sv
// ----------------------------------------------------------------------------
// Luhn checker stream interface
// Valid/ready channel carrying one word of type T per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/luhn_card_number_checker.sv
// ----------------------------------------------------------------------------
// Luhn card number checker
// Streams card digits, checks the mod-10 checksum and classifies the issuer.
// ----------------------------------------------------------------------------
// Digits enter most significant first, one word per cycle, the final digit
// marked by last. Each accepted digit updates the running state in the same
// cycle; a last digit loads the result register, whose word is offered on the
// next cycle, and the state clears for the next number. Throughput is one
// digit per cycle, set by the single register stage between input and result;
// input is held off only while a result word waits and the sink is not ready.
// The digit count saturates at MAX_DIGITS and is reported in five bits.
`default_nettype none

module luhn_card_number_checker #(
    parameter int MAX_DIGITS = lcc_pkg::MAX_DIGITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lcc_stream_if.sink    i_dig,
    lcc_stream_if.source  o_res
);

`include "luhn_card_number_checker_macros.svh"

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    logic [CNT_W-1:0]     r_count, n_count, upd_count;
    logic [3:0]           r_sum_even, n_sum_even, upd_sum_even;
    logic [3:0]           r_sum_odd, n_sum_odd, upd_sum_odd;
    logic [3:0]           r_lead, n_lead, upd_lead;
    logic [3:0]           r_second, n_second, upd_second;
    logic                 r_parity, n_parity, upd_parity;
    logic                 r_out_valid;
    lcc_pkg::t_result_word r_out_data, n_out_data;

    logic                 w_acc;
    lcc_pkg::t_digit_word w_in;
    logic [3:0]           w_plain;
    logic [3:0]           w_dbl;
    logic [3:0]           w_sel;
    lcc_pkg::t_issuer     w_issuer;

    // Accept a digit unless a result word is stuck
    assign i_dig.ready = !r_out_valid || o_res.ready;
    assign w_acc       = i_dig.valid && i_dig.ready;
    assign w_in        = i_dig.data;

    // Digit contributions
    assign w_plain = lcc_pkg::plain_val(w_in.digit);
    assign w_dbl   = lcc_pkg::DBL_TAB[w_in.digit];

    // Update running sums, count and prefix digits
    always_comb begin
        upd_lead   = (r_count == '0) ? w_in.digit : r_lead;
        upd_second = (r_count == CNT_W'(1)) ? w_in.digit : r_second;
        if (!r_parity) begin
            upd_sum_even = lcc_pkg::add_mod10(r_sum_even, w_dbl);
            upd_sum_odd  = lcc_pkg::add_mod10(r_sum_odd, w_plain);
        end else begin
            upd_sum_even = lcc_pkg::add_mod10(r_sum_even, w_plain);
            upd_sum_odd  = lcc_pkg::add_mod10(r_sum_odd, w_dbl);
        end
        upd_parity = !r_parity;
        if (r_count < CNT_W'(MAX_DIGITS)) begin
            upd_count = r_count + CNT_W'(1);
        end else begin
            upd_count = r_count;
        end
    end

    // Clear the state after the last digit
    always_comb begin
        if (w_in.last) begin
            n_count    = '0;
            n_sum_even = '0;
            n_sum_odd  = '0;
            n_lead     = '0;
            n_second   = '0;
            n_parity   = 1'b0;
        end else begin
            n_count    = upd_count;
            n_sum_even = upd_sum_even;
            n_sum_odd  = upd_sum_odd;
            n_lead     = upd_lead;
            n_second   = upd_second;
            n_parity   = upd_parity;
        end
    end

    // Pick the sum by length parity and classify the issuer
    always_comb begin
        w_sel = upd_parity ? upd_sum_odd : upd_sum_even;
        if (upd_count == CNT_W'(lcc_pkg::LEN_FIFTEEN) && upd_lead == 4'd3
                && (upd_second == 4'd4 || upd_second == 4'd7)) begin
            w_issuer = lcc_pkg::ISS_FIFTEEN_3X;
        end else if (upd_count == CNT_W'(lcc_pkg::LEN_SIXTEEN) && upd_lead == 4'd5
                && upd_second inside {[4'd1:4'd5]}) begin
            w_issuer = lcc_pkg::ISS_SIXTEEN_5X;
        end else if ((upd_count == CNT_W'(lcc_pkg::LEN_THIRTEEN)
                || upd_count == CNT_W'(lcc_pkg::LEN_SIXTEEN)) && upd_lead == 4'd4) begin
            w_issuer = lcc_pkg::ISS_LEAD_FOUR;
        end else begin
            w_issuer = lcc_pkg::ISS_NONE;
        end
        n_out_data.valid_res   = (w_sel == 4'd0);
        n_out_data.issuer      = w_issuer;
        n_out_data.digit_count = upd_count[lcc_pkg::COUNT_OUT_W-1:0];
    end

    // Advance the running state on each accepted digit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_sum_even <= '0;
            r_sum_odd  <= '0;
            r_lead     <= '0;
            r_second   <= '0;
            r_parity   <= 1'b0;
        end else if (w_acc) begin
            r_count    <= n_count;
            r_sum_even <= n_sum_even;
            r_sum_odd  <= n_sum_odd;
            r_lead     <= n_lead;
            r_second   <= n_second;
            r_parity   <= n_parity;
        end
    end

    // Hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_acc && w_in.last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_in.last) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out_data;

    // Checks
    `LCC_ASSERT_NEXT(a_last_loads_word, i_clk, i_rst_n, w_acc && w_in.last,
        r_out_valid && r_count == '0 && !r_parity, "last digit did not load result")
    `LCC_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= CNT_W'(MAX_DIGITS), "digit count beyond saturation")
    `LCC_ASSERT_SAME(a_issuer_length, i_clk, i_rst_n,
        r_out_valid && r_out_data.issuer != lcc_pkg::ISS_NONE,
        r_out_data.digit_count == 5'd13 || r_out_data.digit_count == 5'd15
        || r_out_data.digit_count == 5'd16, "issuer class with wrong length")

endmodule

`default_nettype wire

// File: bench/luhn_card_number_checker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Luhn card number checker testbench
// Streams card numbers digit by digit through the checker and compares every
// result word with an in-bench model of the checksum, issuer and count rules.
// A short directed set comes first, then random numbers: mostly well-formed
// issuer prefixes with valid or broken check digits, plus short, long and
// out-of-range digit noise, under several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module luhn_card_number_checker_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 300;

    // Expected-result store and running Luhn model for the digit stream
    class luhn_scoreboard;
        lcc_pkg::t_result_word result_q[$];
        logic [4:0]   digits_seen;
        logic [3:0]   sum_even_dbl;
        logic [3:0]   sum_odd_dbl;
        logic [3:0]   lead;
        logic [3:0]   second;
        logic         parity;
        int           errors;
        int           checked;

        function new();
            errors  = 0;
            checked = 0;
            clear_number();
        endfunction

        function void clear_number();
            digits_seen  = '0;
            sum_even_dbl = '0;
            sum_odd_dbl  = '0;
            lead         = '0;
            second       = '0;
            parity       = 1'b0;
        endfunction

        // Doubled digit: 2d, minus 9 past nine, taken mod 10
        static function int doubled(int d);
            int v;
            v = 2 * d;
            if (v > 9) begin
                v = v - 9;
            end
            return v % 10;
        endfunction

        function int pending();
            return result_q.size();
        endfunction

        // Advance the model by one accepted digit word
        function void note_digit(lcc_pkg::t_digit_word w);
            int                    d;
            int                    plain;
            int                    dbl;
            logic [3:0]            sel;
            lcc_pkg::t_result_word r;
            d     = int'(w.digit);
            plain = d % 10;
            dbl   = doubled(d);
            if (digits_seen == 0) begin
                lead = w.digit;
            end else if (digits_seen == 1) begin
                second = w.digit;
            end
            if (!parity) begin
                sum_even_dbl = 4'((sum_even_dbl + dbl) % 10);
                sum_odd_dbl  = 4'((sum_odd_dbl + plain) % 10);
            end else begin
                sum_even_dbl = 4'((sum_even_dbl + plain) % 10);
                sum_odd_dbl  = 4'((sum_odd_dbl + dbl) % 10);
            end
            parity = ~parity;
            if (digits_seen < lcc_pkg::MAX_DIGITS_DEF) begin
                digits_seen = digits_seen + 5'd1;
            end
            if (!w.last) begin
                return;
            end
            // Parity back at zero means an even total: the even-doubled sum applies
            sel         = parity ? sum_odd_dbl : sum_even_dbl;
            r.valid_res = (sel == 0);
            r.issuer    = lcc_pkg::ISS_NONE;
            if (digits_seen == lcc_pkg::LEN_FIFTEEN && lead == 3
                    && (second == 4 || second == 7)) begin
                r.issuer = lcc_pkg::ISS_FIFTEEN_3X;
            end else if (digits_seen == lcc_pkg::LEN_SIXTEEN && lead == 5 && second >= 1
                         && second <= 5) begin
                r.issuer = lcc_pkg::ISS_SIXTEEN_5X;
            end else if ((digits_seen == lcc_pkg::LEN_THIRTEEN
                          || digits_seen == lcc_pkg::LEN_SIXTEEN) && lead == 4) begin
                r.issuer = lcc_pkg::ISS_LEAD_FOUR;
            end
            r.digit_count = digits_seen;
            result_q.push_back(r);
            clear_number();
        endfunction

        // Compare one accepted result word with the oldest expectation
        function void check_result(lcc_pkg::t_result_word got);
            lcc_pkg::t_result_word exp_w;
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result word valid_res=%0d issuer=%0d count=%0d",
                         $time, got.valid_res, got.issuer, got.digit_count);
                errors++;
                return;
            end
            exp_w = result_q.pop_front();
            checked++;
            if (got.valid_res !== exp_w.valid_res) begin
                $display("%0t: valid_res mismatch: expected %0d, got %0d",
                         $time, exp_w.valid_res, got.valid_res);
                errors++;
            end
            if (got.issuer !== exp_w.issuer) begin
                $display("%0t: issuer mismatch: expected %0d, got %0d",
                         $time, exp_w.issuer, got.issuer);
                errors++;
            end
            if (got.digit_count !== exp_w.digit_count) begin
                $display("%0t: digit_count mismatch: expected %0d, got %0d",
                         $time, exp_w.digit_count, got.digit_count);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    lcc_stream_if #(.T(lcc_pkg::t_digit_word))  dig_if ();
    lcc_stream_if #(.T(lcc_pkg::t_result_word)) res_if ();

    luhn_card_number_checker u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_dig   (dig_if.sink),
        .o_res   (res_if.source)
    );

    luhn_scoreboard sb;
    logic [3:0]     num_q[$];
    int             send_idle_pct;
    int             rcv_stall_pct;
    int             hold_left;
    int             digits_sent;
    int             quiet_cycles;

    // Clock
    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    // Drive result ready: long hold-off when asked, else random stalls
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            res_if.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            res_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // Note accepted words and check results at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                sb.check_result(res_if.data);
            end
            if (dig_if.valid && dig_if.ready) begin
                sb.note_digit(dig_if.data);
            end
        end
    end

    // Watchdog: end the run after too long without any accepted word
    always @(posedge i_clk) begin
        if ((dig_if.valid && dig_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results still expected",
                     $time, sb.pending());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Offer one digit word; start and end at a falling edge
    task automatic push_digit(input logic [3:0] d, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            dig_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        dig_if.valid      <= 1'b1;
        dig_if.data.digit <= d;
        dig_if.data.last  <= last;
        @(posedge i_clk);
        while (!dig_if.ready) begin
            @(posedge i_clk);
        end
        digits_sent++;
        @(negedge i_clk);
    endtask

    // Send the number held in num_q, last mark on its final digit
    task automatic send_number();
        for (int i = 0; i < num_q.size(); i++) begin
            push_digit(num_q[i], i == num_q.size() - 1);
        end
    endtask

    // Drop valid and wait until every expected result has arrived
    task automatic drain();
        dig_if.valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Random digit, out-of-range codes now and then
    function automatic logic [3:0] noisy_digit(int high_pct);
        if ($urandom_range(99) < high_pct) begin
            return 4'($urandom_range(15, 10));
        end
        return 4'($urandom_range(9, 0));
    endfunction

    // Build a random number in num_q; mostly issuer-shaped with a Luhn check digit
    task automatic build_number();
        int kind;
        int len;
        int sum;
        int r;
        kind = $urandom_range(99);
        num_q.delete();
        if (kind < 22) begin
            // Sixteen digits led by 5x
            len = ($urandom_range(9) == 0) ? $urandom_range(17, 14) : lcc_pkg::LEN_SIXTEEN;
            num_q.push_back(($urandom_range(9) == 0) ? noisy_digit(0) : 4'd5);
            num_q.push_back(($urandom_range(4) == 0) ? noisy_digit(10)
                            : 4'($urandom_range(5, 1)));
        end else if (kind < 42) begin
            // Fifteen digits led by 34 or 37
            len = ($urandom_range(9) == 0) ? $urandom_range(16, 14) : lcc_pkg::LEN_FIFTEEN;
            num_q.push_back(($urandom_range(9) == 0) ? noisy_digit(0) : 4'd3);
            num_q.push_back(($urandom_range(4) == 0) ? noisy_digit(10)
                            : (($urandom_range(1) == 0) ? 4'd4 : 4'd7));
        end else if (kind < 64) begin
            // Thirteen or sixteen digits led by 4
            len = ($urandom_range(1) == 0) ? lcc_pkg::LEN_THIRTEEN : lcc_pkg::LEN_SIXTEEN;
            if ($urandom_range(9) == 0) begin
                len = $urandom_range(17, 12);
            end
            num_q.push_back(($urandom_range(9) == 0) ? noisy_digit(10) : 4'd4);
            num_q.push_back(noisy_digit(3));
        end else if (kind < 94) begin
            // Short number, leading zeros and high codes allowed
            len = $urandom_range(12, 1);
            num_q.push_back(noisy_digit(15));
        end else begin
            // Long number, up to past the count saturation
            len = $urandom_range(45, 28);
            num_q.push_back(noisy_digit(5));
        end
        while (num_q.size() > len) begin
            void'(num_q.pop_back());
        end
        while (num_q.size() < len - 1) begin
            num_q.push_back(noisy_digit(3));
        end
        if (num_q.size() < len) begin
            // Check digit from the rest: positions odd from the right are doubled
            sum = 0;
            for (int i = 0; i < num_q.size(); i++) begin
                r = len - 1 - i;
                if (r % 2 == 1) begin
                    sum += luhn_scoreboard::doubled(int'(num_q[i]));
                end else begin
                    sum += int'(num_q[i]) % 10;
                end
            end
            if ($urandom_range(99) < 70) begin
                num_q.push_back(4'((10 - sum % 10) % 10));
            end else begin
                num_q.push_back(noisy_digit(10));
            end
        end
    endtask

    // Run random numbers until the digit total reaches the target
    task automatic run_phase(input int idle_pct, input int stall_pct, input int target);
        send_idle_pct = idle_pct;
        rcv_stall_pct = stall_pct;
        while (digits_sent < target) begin
            build_number();
            send_number();
        end
        drain();
    endtask

    initial begin
        sb            = new();
        i_rst_n       = 1'b0;
        dig_if.valid  = 1'b0;
        dig_if.data   = '0;
        res_if.ready  = 1'b0;
        send_idle_pct = 0;
        rcv_stall_pct = 0;
        hold_left     = 0;
        digits_sent   = 0;
        quiet_cycles  = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: single digits at the extremes, high codes, leading zeros
        num_q = '{4'd0};
        send_number();
        num_q = '{4'd9};
        send_number();
        num_q = '{4'd15};
        send_number();
        num_q = '{4'd10};
        send_number();
        num_q = '{4'd0, 4'd0, 4'd1, 4'd8};
        send_number();
        num_q = '{4'd5, 4'd5};
        send_number();
        num_q = '{4'd13, 4'd7, 4'd2};
        send_number();
        num_q = '{4'd4, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd6};
        send_number();
        drain();

        // Free-running phase with a long receiver hold-off in the middle
        run_phase(0, 0, 200);
        hold_left = HOLD_OFF_CYCLES;
        for (int i = 0; i < 4; i++) begin
            build_number();
            send_number();
        end
        drain();
        run_phase(0, 0, 380);

        run_phase(72, 0, 740);
        run_phase(0, 72, 1100);
        run_phase(24, 24, 1460);

        repeat (8) @(negedge i_clk);
        $display("Sent %0d digits and checked %0d result words across free-running,",
                 digits_sent, sb.checked);
        $display("idle, stall and mixed phases, including a %0d-cycle receiver hold-off.",
                 HOLD_OFF_CYCLES);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
+incdir+src
src/lcc_pkg.sv
src/lcc_stream_if.sv
src/luhn_card_number_checker.sv
bench/luhn_card_number_checker_tb.sv
